// File: rtl/iiee_pkg.sv
// ----------------------------------------------------------------------------
// iiee_pkg
// Types, character codes and operator codes for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iiee_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CHAR_W = 8;

	// operator codes held in the pending operator register
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     div_by_zero;
	} out_item_t;

	// any byte that is not '+', '-' or '*' acts as a divide
	function automatic logic [1:0] op_of_char(input logic [CHAR_W-1:0] c);
		logic [1:0] op;
		priority if (c == CHAR_PLUS) op = OP_ADD;
		else if (c == CHAR_MINUS)    op = OP_SUB;
		else if (c == CHAR_STAR)     op = OP_MUL;
		else                         op = OP_DIV;
		return op;
	endfunction

endpackage

// File: rtl/iiee_stream_if.sv
// ----------------------------------------------------------------------------
// iiee_stream_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface iiee_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/integer_infix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// integer_infix_expression_evaluator_top
// Evaluates an integer infix expression fed one character per item.
// ----------------------------------------------------------------------------
// Characters arrive on chars, one per item, with last_char marking the end of
// the expression; one result item leaves on results for each final character.
// Digits build the current number, spaces are skipped, '+', '-' and '*' are
// themselves and every other byte acts as '/', with '*' and '/' binding tighter.
// Arithmetic wraps at 32 bits and division truncates toward zero; a zero
// divisor sets div_by_zero and forces value to 0. A digit or space that is not
// final leaves the sequencer idle; '+', '-' and '*' pass through the apply
// state; an operator that completes a division also runs the radix-2 restoring
// divider, which resolves one quotient bit per cycle and is shared by every
// division. A final character of any kind applies the pending operator as an
// operator character does, then forms the result in the finish state, and
// waits there while an earlier result is not yet taken.
// ----------------------------------------------------------------------------
module integer_infix_expression_evaluator_top (
	input  logic           clk,
	input  logic           arst_n,
	iiee_stream_if.sink    chars,
	iiee_stream_if.source  results
);
	import iiee_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_APPLY  = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_DIVEND = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic [2:0]        state_q;
	logic [DATA_W-1:0] running_sum_q;
	logic [DATA_W-1:0] last_term_q;
	logic [DATA_W-1:0] current_number_q;
	logic [1:0]        pending_op_q;
	logic              error_seen_q;
	logic [1:0]        char_op_q;
	logic              last_q;

	logic [DATA_W-1:0] div_rem_q;
	logic [DATA_W-1:0] div_quo_q;
	logic [DATA_W-1:0] div_dsr_q;
	logic              div_neg_q;
	logic [CNT_W-1:0]  div_cnt_q;

	logic              out_valid_q;
	out_item_t         out_item_q;

	in_item_t          in_item;
	logic              accept;
	logic              is_digit;
	logic              apply;
	logic [DATA_W-1:0] digit_value;
	logic [DATA_W-1:0] number_next;
	logic [DATA_W-1:0] mag_dividend;
	logic [DATA_W-1:0] mag_divisor;
	logic [DATA_W-1:0] rem_shifted;
	logic [DATA_W:0]   trial;
	logic              out_free;
	logic [DATA_W-1:0] after_state;

	assign in_item     = chars.payload;
	assign chars.ready = (state_q == ST_IDLE);
	assign accept      = chars.valid && chars.ready;

	assign is_digit    = (in_item.char_code >= CHAR_ZERO) && (in_item.char_code <= CHAR_NINE);
	assign apply       = (!is_digit && (in_item.char_code != CHAR_SPACE)) || in_item.last_char;
	assign digit_value = {{(DATA_W-CHAR_W){1'b0}}, in_item.char_code - CHAR_ZERO};
	assign number_next = (current_number_q << 3) + (current_number_q << 1) + digit_value;

	assign mag_dividend = last_term_q[DATA_W-1] ? (~last_term_q + 1'b1) : last_term_q;
	assign mag_divisor  = current_number_q[DATA_W-1] ? (~current_number_q + 1'b1)
		: current_number_q;

	// one restoring step: shift in the next dividend bit and try the subtract
	assign rem_shifted = {div_rem_q[DATA_W-2:0], div_quo_q[DATA_W-1]};
	assign trial       = {1'b0, rem_shifted} - {1'b0, div_dsr_q};

	assign out_free    = !out_valid_q || results.ready;
	assign after_state = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			running_sum_q    <= '0;
			last_term_q      <= '0;
			current_number_q <= '0;
			pending_op_q     <= OP_ADD;
			error_seen_q     <= 1'b0;
			div_cnt_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_digit) begin
							current_number_q <= number_next;
						end
						if (apply) begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					unique case (pending_op_q)
						OP_ADD: begin
							running_sum_q <= running_sum_q + last_term_q;
							last_term_q   <= current_number_q;
						end
						OP_SUB: begin
							running_sum_q <= running_sum_q + last_term_q;
							last_term_q   <= ~current_number_q + 1'b1;
						end
						OP_MUL: begin
							last_term_q <= last_term_q * current_number_q;
						end
						OP_DIV: begin
							if (current_number_q == '0) begin
								error_seen_q <= 1'b1;
								last_term_q  <= '0;
							end
						end
						default: begin
						end
					endcase
					if (pending_op_q == OP_DIV && current_number_q != '0) begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						pending_op_q     <= char_op_q;
						current_number_q <= '0;
						state_q          <= last_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CNT_W'(DATA_W - 1)) begin
						state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: begin
					last_term_q      <= div_neg_q ? (~div_quo_q + 1'b1) : div_quo_q;
					pending_op_q     <= char_op_q;
					current_number_q <= '0;
					state_q          <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					// hold until the output register is free, then clear for the next expression
					if (out_free) begin
						running_sum_q    <= after_state;
						last_term_q      <= after_state;
						current_number_q <= after_state;
						pending_op_q     <= OP_ADD;
						error_seen_q     <= 1'b0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the result item until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			char_op_q <= op_of_char(in_item.char_code);
			last_q    <= in_item.last_char;
		end
		if (state_q == ST_APPLY) begin
			div_rem_q <= '0;
			div_quo_q <= mag_dividend;
			div_dsr_q <= mag_divisor;
			div_neg_q <= last_term_q[DATA_W-1] ^ current_number_q[DATA_W-1];
		end else if (state_q == ST_DIV) begin
			if (trial[DATA_W]) begin
				div_rem_q <= rem_shifted;
				div_quo_q <= {div_quo_q[DATA_W-2:0], 1'b0};
			end else begin
				div_rem_q <= trial[DATA_W-1:0];
				div_quo_q <= {div_quo_q[DATA_W-2:0], 1'b1};
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_item_q.value       <= error_seen_q ? '0 : (running_sum_q + last_term_q);
			out_item_q.div_by_zero <= error_seen_q;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_item_q;

	// digits and spaces that are not final leave the sequencer idle
	a_plain_char_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !apply |=> state_q == ST_IDLE)
		else $error("plain character left the idle state");

	a_div_runs_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_cnt_q != CNT_W'(DATA_W - 1) |=> state_q == ST_DIV)
		else $error("divider left before all quotient bits");

	a_error_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.payload.div_by_zero |-> results.payload.value == '0)
		else $error("division error result is not zero");

	a_finish_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_free |=>
			running_sum_q == '0 && last_term_q == '0 && pending_op_q == OP_ADD
			&& !error_seen_q && out_valid_q)
		else $error("expression state not cleared after result");

endmodule

// File: tb/sv/integer_infix_expression_evaluator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_infix_expression_evaluator_top_tb
// Drives expressions into the evaluator one character per item. A model of
// the running sum, open term and pending operator predicts every result.
// Each result item is checked field by field as it leaves. Both channels
// idle at random, and once the result side holds off long enough to stall
// the character side.
// ----------------------------------------------------------------------------
module integer_infix_expression_evaluator_top_tb;

	import iiee_pkg::*;

	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
	localparam int RESULT_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400_000;

	logic clk;
	logic arst_n;

	iiee_stream_if #(.payload_t(in_item_t))  chars_if ();
	iiee_stream_if #(.payload_t(out_item_t)) results_if ();

	integer_infix_expression_evaluator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	// evaluator model state
	logic [DATA_W-1:0] acc_sum;
	logic [DATA_W-1:0] open_term;
	logic [DATA_W-1:0] num_val;
	logic [1:0]        pend_op;
	logic              dz_flag;
	out_item_t         results_due[$];

	logic [CHAR_W-1:0] char_buf[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;
	int chars_sent = 0;
	int results_checked = 0;
	int zero_div_results = 0;
	int mismatches = 0;
	int cycle_count = 0;

	always #2 clk = ~clk;

	function automatic logic [DATA_W-1:0] quot_trunc(input logic [DATA_W-1:0] num,
			input logic [DATA_W-1:0] den);
		logic [DATA_W-1:0] mag_n, mag_d, q;
		mag_n = num[DATA_W-1] ? -num : num;
		mag_d = den[DATA_W-1] ? -den : den;
		q = mag_n / mag_d;
		return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
	endfunction

	task automatic clear_model();
		acc_sum = '0;
		open_term = '0;
		num_val = '0;
		pend_op = OP_ADD;
		dz_flag = 1'b0;
	endtask

	task automatic eval_char(input in_item_t it);
		logic      is_dig;
		out_item_t res;
		is_dig = (it.char_code >= CHAR_ZERO) && (it.char_code <= CHAR_NINE);
		if (is_dig)
			num_val = num_val * 10 + DATA_W'(it.char_code - CHAR_ZERO);
		if ((!is_dig && it.char_code != CHAR_SPACE) || it.last_char) begin
			case (pend_op)
				OP_ADD: begin
					acc_sum = acc_sum + open_term;
					open_term = num_val;
				end
				OP_SUB: begin
					acc_sum = acc_sum + open_term;
					open_term = -num_val;
				end
				OP_MUL: begin
					open_term = open_term * num_val;
				end
				OP_DIV: begin
					if (num_val == '0) begin
						dz_flag = 1'b1;
						open_term = '0;
					end else begin
						open_term = quot_trunc(open_term, num_val);
					end
				end
			endcase
			if (it.char_code == CHAR_PLUS)
				pend_op = OP_ADD;
			else if (it.char_code == CHAR_MINUS)
				pend_op = OP_SUB;
			else if (it.char_code == CHAR_STAR)
				pend_op = OP_MUL;
			else
				pend_op = OP_DIV;
			num_val = '0;
		end
		if (it.last_char) begin
			res.value = dz_flag ? '0 : acc_sum + open_term;
			res.div_by_zero = dz_flag;
			results_due.insert(results_due.size(), res);
			clear_model();
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// append one character to the expression being built
	task automatic add_char(input logic [CHAR_W-1:0] c);
		char_buf.insert(char_buf.size(), c);
	endtask

	// predict on every accepted character
	always @(posedge clk) begin
		if (arst_n && chars_if.valid && chars_if.ready)
			eval_char(chars_if.payload);
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (results_due.size() == 0) begin
				flag_mismatch($sformatf("result with none due: value %0d div_by_zero %0b",
					results_if.payload.value, results_if.payload.div_by_zero));
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (want.div_by_zero)
					zero_div_results++;
				if (results_if.payload.value !== want.value)
					flag_mismatch($sformatf("value: got %0d, expected %0d",
						results_if.payload.value, want.value));
				if (results_if.payload.div_by_zero !== want.div_by_zero)
					flag_mismatch($sformatf("div_by_zero: got %0b, expected %0b",
						results_if.payload.div_by_zero, want.div_by_zero));
			end
		end
	end

	// result side: random stalls, plus a long hold-off whenever one is asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			results_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_asked != holds_done) begin
			results_if.ready <= 1'b0;
			hold_left <= RESULT_HOLD_CYCLES - 1;
			holds_done <= holds_done + 1;
		end else begin
			results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, results_due.size());
			$display("[integer_infix_expression_evaluator_top] ERROR");
			$finish;
		end
	end

	// Leaves valid high after the handshake; the next call either drops it
	// or replaces the payload in the same step.
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.payload <= '{char_code: c, last_char: fin};
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_buffer();
		foreach (char_buf[i])
			send_char(char_buf[i], i == char_buf.size() - 1);
		char_buf.delete();
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	function automatic logic [CHAR_W-1:0] other_divide_byte();
		logic [CHAR_W-1:0] b;
		do
			b = CHAR_W'($urandom_range(0, 255));
		while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SPACE || b == CHAR_PLUS ||
			b == CHAR_MINUS || b == CHAR_STAR);
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] random_digit();
		return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
	endfunction

	// well-formed expression with random content and an occasional odd ending
	task automatic build_expr();
		int n_terms, n_digits, pick;
		logic zero_div;
		n_terms = $urandom_range(1, 4);
		for (int t = 0; t < n_terms; t++) begin
			zero_div = 1'b0;
			if (t != 0) begin
				pick = $urandom_range(0, 9);
				if ($urandom_range(0, 4) == 0)
					add_char(CHAR_SPACE);
				case (pick)
					0, 1, 2: add_char(CHAR_PLUS);
					3, 4:    add_char(CHAR_MINUS);
					5, 6:    add_char(CHAR_STAR);
					7, 8:    add_char(CHAR_SLASH);
					default: add_char(other_divide_byte());
				endcase
				zero_div = (pick >= 7) && ($urandom_range(0, 5) == 0);
			end else if ($urandom_range(0, 5) == 0) begin
				add_char(CHAR_MINUS);
			end
			if ($urandom_range(0, 4) == 0)
				add_char(CHAR_SPACE);
			if (zero_div) begin
				add_char(CHAR_ZERO);
			end else begin
				n_digits = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 11) :
					$urandom_range(1, 3);
				repeat (n_digits)
					add_char(random_digit());
			end
		end
		pick = $urandom_range(0, 9);
		if (pick == 0)
			add_char(CHAR_SPACE);
		else if (pick == 1)
			add_char($urandom_range(0, 1) ? CHAR_STAR : other_divide_byte());
	endtask

	// broken input: any byte at all, half of them digits
	task automatic build_noise();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1))
				add_char(random_digit());
			else
				add_char(CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		// most negative over minus one, divisor wrapping from 2^33-1
		queue_text("-2147483648/8589934591");
		send_buffer();
		// 0xFF as a divide, then a zero divisor
		queue_text("9*3+");
		add_char(8'hFF);
		add_char(CHAR_ZERO);
		send_buffer();
		// 0x00 as a divide, expression closed by a space
		queue_text("7");
		add_char(8'h00);
		queue_text("2 ");
		send_buffer();
		// expression closed by an operator
		queue_text("5-");
		send_buffer();
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_chars);
		int start;
		start = chars_sent;
		send_idle_pct = snd_pct;
		recv_idle_pct <= rcv_pct;
		while (chars_sent - start < n_chars) begin
			if ($urandom_range(0, 6) == 0)
				build_noise();
			else
				build_expr();
			send_buffer();
		end
	endtask

	task automatic test_result_backpressure();
		string ops;
		ops = "+-*/";
		send_idle_pct = 0;
		recv_idle_pct <= 20;
		holds_asked <= holds_asked + 1;
		// short expressions pile up results behind the hold
		repeat (16) begin
			add_char(random_digit());
			add_char(ops[$urandom_range(0, 3)]);
			add_char(random_digit());
			send_buffer();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.payload = '0;
		results_if.ready = 1'b0;
		clear_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(20, 62, 180);
		test_random_traffic(62, 20, 180);
		test_result_backpressure();
		test_random_traffic(0, 0, 150);
		chars_if.valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d characters, checked %0d results (%0d with a zero divisor)",
			chars_sent, results_checked, zero_div_results);
		$display("idling on either side and none, one %0d-cycle result hold, %0d mismatches",
			RESULT_HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("[integer_infix_expression_evaluator_top] OK");
		else
			$display("[integer_infix_expression_evaluator_top] ERROR");
		$finish;
	end

endmodule
